@@ rtl/core/ffha_pkg.sv @@
`default_nettype none

package ffha_pkg;

   localparam int ARENA_BYTES_DEF  = 65536;
   localparam int ALIGN_BYTES_DEF  = 8;
   localparam int HEADER_BYTES_DEF = 24;

   localparam int MIN_CAP_W = 13;
   localparam int SIZE_W    = 16;
   localparam int STATUS_W  = 2;

   localparam logic [MIN_CAP_W-1:0] MIN_CAP_RESET = MIN_CAP_W'(24);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/first_fit_heap_allocator.sv @@
`default_nettype none

// First-fit allocator over a fixed arena whose block headers sit in a
// single-port-write, single-port-read header memory indexed by byte offset.
// A request is taken when start is high and busy is low; busy stays high
// until the result beat, which appears for one cycle on rsp_valid and cannot
// be held off. After reset the block writes the initial whole-arena header in
// S_INIT before it accepts work. An allocate rounds the size in S_DIV (a
// reciprocal multiply) and S_QSET (the scale and the minimum), then takes an
// S_AWALK and an S_AHDR step per block visited in the chain, an S_MRG step per
// free neighbor merged plus one to close the merge unless it runs to the arena
// end, and S_AFIT, plus S_ASPL for a split, to take the block. A free with an
// offset below the header size answers in the next cycle without going busy;
// otherwise it takes an S_FWALK and an S_FHDR step per block walked before the
// target, S_FWALK and S_FMARK to reach and mark the target and the same merge
// steps. The result beat follows in the cycle after the last step. Walk and
// merge steps wait on the registered memory read; time grows with the chain.
module first_fit_heap_allocator #(
   parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
   parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_op,
   input  wire logic [ffha_pkg::SIZE_W-1:0]     req_size,
   input  wire logic [ffha_pkg::SIZE_W-1:0]     req_free_offset,

   output logic                                 rsp_valid,
   output logic [ffha_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ffha_pkg::SIZE_W-1:0]          rsp_alloc_offset,

   input  wire logic                            csr_write,
   input  wire logic [ffha_pkg::MIN_CAP_W-1:0]  csr_wdata
);

   localparam int ADDR_W   = $clog2(ARENA_BYTES);
   localparam int ENTRY_W  = ADDR_W + 1;
   localparam int WW       = ((ADDR_W > ffha_pkg::SIZE_W + 1) ? ADDR_W
                                                               : ffha_pkg::SIZE_W + 1) + 2;
   localparam int VAL_W    = ffha_pkg::SIZE_W + 1;
   localparam int RECIP_SH = VAL_W + $clog2(ALIGN_BYTES);
   localparam int PROD_W   = VAL_W + RECIP_SH + 1;

   localparam logic [WW-1:0]    ARENA_W  = WW'(ARENA_BYTES);
   localparam logic [WW-1:0]    HDR_W    = WW'(HEADER_BYTES);
   localparam logic [WW-1:0]    ALIGN_W  = WW'(ALIGN_BYTES);
   localparam logic [VAL_W-1:0] ALIGN_M1 = VAL_W'(ALIGN_BYTES - 1);
   localparam logic [RECIP_SH:0] RECIP_M =
      (RECIP_SH + 1)'((2 ** RECIP_SH + ALIGN_BYTES - 1) / ALIGN_BYTES);
   localparam logic [ADDR_W-1:0] INIT_CAP = ADDR_W'(ARENA_BYTES - HEADER_BYTES);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_AWALK = 4'd3;
   localparam logic [3:0] S_AHDR  = 4'd4;
   localparam logic [3:0] S_MRG   = 4'd5;
   localparam logic [3:0] S_AFIT  = 4'd6;
   localparam logic [3:0] S_ASPL  = 4'd7;
   localparam logic [3:0] S_FWALK = 4'd8;
   localparam logic [3:0] S_FHDR  = 4'd9;
   localparam logic [3:0] S_FMARK = 4'd10;
   localparam logic [3:0] S_QSET  = 4'd11;

   logic [ENTRY_W-1:0] hdr_mem [ARENA_BYTES];
   logic [ENTRY_W-1:0] hdr_rd_ff;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;

   logic [3:0]                      state_ff, state_in;
   logic                            op_ff, op_in;
   logic [WW-1:0]                   h_ff, h_in;
   logic [WW-1:0]                   n_ff, n_in;
   logic [WW-1:0]                   cap_ff, cap_in;
   logic [WW-1:0]                   q_ff, q_in;
   logic [WW-1:0]                   target_ff, target_in;
   logic [VAL_W-1:0]                val_ff, val_in;
   logic [ffha_pkg::MIN_CAP_W-1:0]  min_cap_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ffha_pkg::SIZE_W-1:0]     rsp_offset_ff, rsp_offset_in;

   logic                rd_free;
   logic [WW-1:0]       rd_cap;
   logic [WW-1:0]       h_next;
   logic [WW-1:0]       n_merge;
   logic [WW-1:0]       cap_merge;
   logic [WW-1:0]       min_w;
   logic [WW-1:0]       off_full;
   logic [PROD_W-1:0]   recip_prod;
   logic [WW-1:0]       q_align;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hdr_mem[mem_waddr] <= mem_wdata;
      end
      hdr_rd_ff <= hdr_mem[mem_raddr];
   end

   always_comb begin
      rd_free    = hdr_rd_ff[ADDR_W];
      rd_cap     = WW'(hdr_rd_ff[ADDR_W-1:0]);
      h_next     = h_ff + HDR_W + rd_cap;
      n_merge    = n_ff + HDR_W + rd_cap;
      cap_merge  = cap_ff + HDR_W + rd_cap;
      min_w      = WW'(min_cap_ff);
      off_full   = h_ff + HDR_W;
      // quotient by reciprocal: 17-bit value times a short constant
      recip_prod = PROD_W'(val_ff) * PROD_W'(RECIP_M);
      q_align    = WW'(val_ff) * ALIGN_W;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      h_in          = h_ff;
      n_in          = n_ff;
      cap_in        = cap_ff;
      q_in          = q_ff;
      target_in     = target_ff;
      val_in        = val_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      mem_we        = 1'b0;
      mem_waddr     = h_ff[ADDR_W-1:0];
      mem_wdata     = {1'b1, cap_ff[ADDR_W-1:0]};
      mem_raddr     = h_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {1'b1, INIT_CAP};
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               op_in     = req_op;
               h_in      = '0;
               target_in = WW'(req_free_offset) - HDR_W;
               val_in    = VAL_W'(req_size) + ALIGN_M1;
               if (req_op == ffha_pkg::OP_ALLOC) begin
                  state_in = S_DIV;
               end else if (WW'(req_free_offset) < HDR_W) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffha_pkg::ST_FREED;
                  rsp_offset_in = '0;
               end else begin
                  state_in = S_FWALK;
               end
            end
         end
         S_DIV: begin
            val_in   = recip_prod[RECIP_SH +: VAL_W];
            state_in = S_QSET;
         end
         S_QSET: begin
            q_in     = (q_align < min_w) ? min_w : q_align;
            state_in = S_AWALK;
         end
         S_AWALK: begin
            if (h_ff < ARENA_W) begin
               state_in = S_AHDR;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffha_pkg::ST_NO_FIT;
               rsp_offset_in = '0;
               state_in      = S_IDLE;
            end
         end
         S_AHDR: begin
            if (rd_free) begin
               cap_in = rd_cap;
               n_in   = h_next;
               if (h_next < ARENA_W) begin
                  mem_raddr = h_next[ADDR_W-1:0];
                  state_in  = S_MRG;
               end else begin
                  state_in = S_AFIT;
               end
            end else begin
               h_in     = h_next;
               state_in = S_AWALK;
            end
         end
         S_MRG: begin
            if (rd_free && (n_merge < ARENA_W)) begin
               cap_in    = cap_merge;
               n_in      = n_merge;
               mem_raddr = n_merge[ADDR_W-1:0];
            end else begin
               // chain end or used neighbor: store the merged capacity
               if (rd_free) begin
                  cap_in    = cap_merge;
                  n_in      = n_merge;
                  mem_wdata = {1'b1, cap_merge[ADDR_W-1:0]};
               end
               mem_we = 1'b1;
               if (op_ff == ffha_pkg::OP_FREE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffha_pkg::ST_FREED;
                  rsp_offset_in = '0;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_AFIT;
               end
            end
         end
         S_AFIT: begin
            if (cap_ff >= q_ff) begin
               mem_we = 1'b1;
               if ((q_ff + HDR_W + min_w) <= cap_ff) begin
                  mem_wdata = {1'b0, q_ff[ADDR_W-1:0]};
                  state_in  = S_ASPL;
               end else begin
                  mem_wdata     = {1'b0, cap_ff[ADDR_W-1:0]};
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffha_pkg::ST_ALLOCATED;
                  rsp_offset_in = off_full[ffha_pkg::SIZE_W-1:0];
                  state_in      = S_IDLE;
               end
            end else begin
               h_in     = n_ff;
               state_in = S_AWALK;
            end
         end
         S_ASPL: begin
            mem_we        = 1'b1;
            mem_waddr     = ADDR_W'(off_full + q_ff);
            mem_wdata     = {1'b1, ADDR_W'(cap_ff - q_ff - HDR_W)};
            rsp_valid_in  = 1'b1;
            rsp_status_in = ffha_pkg::ST_ALLOCATED;
            rsp_offset_in = off_full[ffha_pkg::SIZE_W-1:0];
            state_in      = S_IDLE;
         end
         S_FWALK: begin
            if ((h_ff < ARENA_W) && (h_ff < target_ff)) begin
               state_in = S_FHDR;
            end else if ((h_ff < ARENA_W) && (h_ff == target_ff)) begin
               state_in = S_FMARK;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffha_pkg::ST_FREED;
               rsp_offset_in = '0;
               state_in      = S_IDLE;
            end
         end
         S_FHDR: begin
            h_in     = h_next;
            state_in = S_FWALK;
         end
         S_FMARK: begin
            cap_in = rd_cap;
            n_in   = h_next;
            if (h_next < ARENA_W) begin
               mem_raddr = h_next[ADDR_W-1:0];
               state_in  = S_MRG;
            end else begin
               mem_we        = 1'b1;
               mem_wdata     = {1'b1, rd_cap[ADDR_W-1:0]};
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffha_pkg::ST_FREED;
               rsp_offset_in = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         min_cap_ff   <= ffha_pkg::MIN_CAP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            min_cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      h_ff          <= h_in;
      n_ff          <= n_in;
      cap_ff        <= cap_in;
      q_ff          <= q_in;
      target_ff     <= target_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_offset = rsp_offset_ff;

endmodule

`default_nettype wire

@@ tb/ffha_checker.sv @@
module ffha_checker
   import ffha_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_op,
   input  logic [SIZE_W-1:0]     req_size,
   input  logic [SIZE_W-1:0]     req_free_offset,
   input  logic                  rsp_valid,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [SIZE_W-1:0]     rsp_alloc_offset,
   input  logic                  csr_write,
   input  logic [MIN_CAP_W-1:0]  csr_wdata,
   output int                    outstanding,
   output int                    fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARENA = ARENA_BYTES_DEF;
   localparam int ALIGN = ALIGN_BYTES_DEF;
   localparam int HDR   = HEADER_BYTES_DEF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SIZE_W-1:0]   offset;
   } heap_reply_type;

   int unsigned            cap_at [ARENA];
   bit                     free_at [ARENA];
   logic [MIN_CAP_W-1:0]   min_cap;
   heap_reply_type         replies_due [$];
   heap_reply_type         want;
   int                     errors = 0;

   assign fail_count = errors;

   // absorb every free block that directly follows block h
   function automatic void absorb_followers(int unsigned h);
      int unsigned n;
      n = h + HDR + cap_at[h];
      while (n < ARENA && free_at[n]) begin
         cap_at[h] = cap_at[h] + HDR + cap_at[n];
         n = h + HDR + cap_at[h];
      end
   endfunction

   function automatic heap_reply_type serve_alloc(logic [SIZE_W-1:0] size);
      int unsigned q;
      int unsigned h;
      int unsigned whole;
      heap_reply_type r;
      r.status = ST_NO_FIT;
      r.offset = '0;
      q = (32'(size) + ALIGN - 1) / ALIGN * ALIGN;
      if (q < min_cap) q = min_cap;
      h = 0;
      while (h < ARENA) begin
         if (free_at[h]) begin
            absorb_followers(h);
            if (cap_at[h] >= q) begin
               whole = cap_at[h];
               if (q + HDR + min_cap <= whole) begin
                  cap_at[h + HDR + q]  = whole - q - HDR;
                  free_at[h + HDR + q] = 1'b1;
                  cap_at[h]            = q;
               end
               free_at[h] = 1'b0;
               r.status   = ST_ALLOCATED;
               r.offset   = SIZE_W'(h + HDR);
               return r;
            end
         end
         h = h + HDR + cap_at[h];
      end
      return r;
   endfunction

   function automatic heap_reply_type serve_free(logic [SIZE_W-1:0] where);
      int unsigned target;
      int unsigned h;
      heap_reply_type r;
      r.status = ST_FREED;
      r.offset = '0;
      if (where >= HDR) begin
         target = where - HDR;
         h = 0;
         while (h < ARENA && h < target) h = h + HDR + cap_at[h];
         if (h == target) begin
            free_at[h] = 1'b1;
            absorb_followers(h);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (cap_at[i]) begin
            cap_at[i]  = 0;
            free_at[i] = 1'b0;
         end
         cap_at[0]  = ARENA - HDR;
         free_at[0] = 1'b1;
         min_cap    = MIN_CAP_RESET;
         replies_due.delete();
      end else begin
         if (csr_write) min_cap = csr_wdata;
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               errors++;
               $display("%0t ffha_checker: beat with nothing expected, status %0d offset %0d",
                        $time, rsp_status, rsp_alloc_offset);
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t ffha_checker: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_alloc_offset !== want.offset) begin
                  errors++;
                  $display("%0t ffha_checker: alloc_offset expected %0d actual %0d",
                           $time, want.offset, rsp_alloc_offset);
               end
            end
         end
         if (start && !busy)
            replies_due.push_back(req_op == OP_FREE ? serve_free(req_free_offset)
                                                    : serve_alloc(req_size));
      end
      outstanding <= replies_due.size();
   end

endmodule

@@ tb/tb.sv @@
module tb;
   import ffha_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   req_op = OP_ALLOC;
   logic [SIZE_W-1:0]      req_size = '0;
   logic [SIZE_W-1:0]      req_free_offset = '0;
   logic                   csr_write = 1'b0;
   logic [MIN_CAP_W-1:0]   csr_wdata = '0;
   logic                   busy;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [SIZE_W-1:0]      rsp_alloc_offset;
   int                     outstanding;
   int                     fail_count;
   int                     idle_cycles = 0;
   bit                     gaps_on = 1'b1;
   logic [SIZE_W-1:0]      live_offsets [$];
   logic [SIZE_W-1:0]      freed_offsets [$];

   first_fit_heap_allocator dut (.*);
   ffha_checker chk (.*);

   always #6 clock = ~clock;

   always @(posedge clock)
      if (rsp_valid && rsp_status == ST_ALLOCATED) live_offsets.push_back(rsp_alloc_offset);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic issue(input logic op, input logic [SIZE_W-1:0] size,
                        input logic [SIZE_W-1:0] where);
      if (gaps_on && $urandom_range(0, 99) < 25) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_op          <= op;
      req_size        <= size;
      req_free_offset <= where;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic request_bytes(input logic [SIZE_W-1:0] size);
      issue(OP_ALLOC, size, SIZE_W'($urandom));
   endtask

   task automatic return_block(input logic [SIZE_W-1:0] where);
      issue(OP_FREE, SIZE_W'($urandom), where);
      freed_offsets.push_back(where);
      if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
   endtask

   // quiesce: every beat answered, block not busy
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_min_cap(input logic [MIN_CAP_W-1:0] value);
      settle();
      csr_wdata <= value;
      csr_write <= 1'b1;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic return_all();
      settle();
      while (live_offsets.size() != 0) return_block(live_offsets.pop_front());
      settle();
   endtask

   task automatic random_item();
      int roll;
      int k;
      logic [SIZE_W-1:0] pick;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         case ($urandom_range(0, 4))
            0: pick = '0;
            1: pick = SIZE_W'($urandom);
            2: pick = SIZE_W'($urandom_range(1, 23));
            3: pick = freed_offsets.size() != 0 ?
                      freed_offsets[$urandom_range(0, freed_offsets.size() - 1)] : '1;
            default: pick = live_offsets.size() != 0 ?
                      SIZE_W'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]
                              + 16'd8) : 16'd25;
         endcase
         return_block(pick);
      end else if (live_offsets.size() != 0 && (roll < 45 || live_offsets.size() > 24)) begin
         k = $urandom_range(0, live_offsets.size() - 1);
         pick = live_offsets[k];
         live_offsets.delete(k);
         return_block(pick);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 12)      pick = SIZE_W'($urandom_range(0, 40));
         else if (roll < 82) pick = SIZE_W'($urandom_range(0, 3000));
         else if (roll < 94) pick = SIZE_W'($urandom_range(0, 20000));
         else                pick = SIZE_W'($urandom_range(0, 65535));
         request_bytes(pick);
      end
   endtask

   initial begin
      int phase_caps [7];
      phase_caps = '{24, 0, 4095, 4096, 13, 0, 24};
      phase_caps[5] = $urandom_range(1, 4095);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // null free, short offset, non-block, size corners, then double and off-block frees
      return_block(16'd0);
      return_block(16'd23);
      return_block(16'hFFFF);
      request_bytes(16'd0);
      request_bytes(16'd1);
      request_bytes(16'd7);
      request_bytes(16'd8);
      request_bytes(16'd9);
      request_bytes(16'hFFFF);
      return_block(16'd24);
      return_block(16'd24);
      return_block(16'd25);
      request_bytes(16'd16);
      return_all();
      // whole arena in one block, then nothing left
      request_bytes(16'd65512);
      request_bytes(16'd1);
      return_all();
      // zero-capacity blocks
      set_min_cap(13'd0);
      request_bytes(16'd0);
      request_bytes(16'd0);
      request_bytes(16'd5);
      return_all();
      set_min_cap(13'd13);
      request_bytes(16'd1);
      request_bytes(16'd20);
      set_min_cap(13'd4096);
      request_bytes(16'd0);
      request_bytes(16'd4100);

      for (int p = 0; p < 7; p++) begin
         if (p % 2 == 0) return_all();
         set_min_cap(MIN_CAP_W'(phase_caps[p]));
         if (p == 6) gaps_on = 1'b0;
         repeat (78) random_item();
      end

      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

@@ first_fit_heap_allocator.f @@
rtl/core/ffha_pkg.sv
rtl/core/first_fit_heap_allocator.sv
tb/ffha_checker.sv
tb/tb.sv
